// ===== rtl/swsp_pkg.sv =====
// ---------------------------------------------------------------------------
// swsp_pkg: shared types and constants for the shell word splitter
// Byte codes, quote modes and the work entry passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package swsp_pkg;

  // Bytes with a special meaning to the splitter
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;

  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Work queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    MODE_OUT  = 2'd0,
    MODE_BARE = 2'd1,
    MODE_SQ   = 2'd2,
    MODE_DQ   = 2'd3
  } mode_t;

  // One byte-level result: a kept byte or a bare word start
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              has;
    logic              ws;
  } byte_res_t;

  // Everything one input item produces, in order: r0, r1, then flush
  typedef struct packed {
    logic [1:0]         n;
    byte_res_t          r0;
    byte_res_t          r1;
    logic               done;
    logic [COUNT_W-1:0] count;
  } plan_t;

  // Result item as it leaves the block
  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               out_has_char;
    logic               word_start;
    logic               string_done;
    logic [COUNT_W-1:0] word_count;
    logic               run_last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/swsp_if.sv =====
// ---------------------------------------------------------------------------
// swsp_if: item channels of the shell word splitter
// Input byte channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface swsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_has_char;
  logic       end_of_string;

  modport source (output valid, in_char, in_has_char, end_of_string, input ready);
  modport sink   (input valid, in_char, in_has_char, end_of_string, output ready);
endinterface

interface swsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        out_has_char;
  logic        word_start;
  logic        string_done;
  logic [15:0] word_count;
  logic        run_last;

  modport source (output valid, out_char, out_has_char, word_start, string_done,
                  word_count, run_last, input ready);
  modport sink   (input valid, out_char, out_has_char, word_start, string_done,
                  word_count, run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/swsp_front.sv =====
// ---------------------------------------------------------------------------
// swsp_front: byte classifier
// Track quote mode and pending backslash; turn each item into a work entry.
// ---------------------------------------------------------------------------
`default_nettype none

module swsp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_char,
  input  wire logic            in_has_char,
  input  wire logic            end_of_string,
  input  wire logic            q_full,
  output logic                 push,
  output swsp_pkg::plan_t      push_data
);

  typedef struct packed {
    swsp_pkg::mode_t                  q;
    logic                             p;
    logic [swsp_pkg::COUNT_W-1:0]     cnt;
    swsp_pkg::plan_t                  pl;
  } ctx_t;

  swsp_pkg::mode_t               mode, mode_next;
  logic                          pend, pend_next;
  logic [swsp_pkg::COUNT_W-1:0]  words, words_next;
  ctx_t                          x;
  logic                          accept;

  function automatic logic is_space(input logic [7:0] c);
    return c == swsp_pkg::CH_SPACE || c == swsp_pkg::CH_TAB ||
           c == swsp_pkg::CH_CR || c == swsp_pkg::CH_LF;
  endfunction

  // Append one byte-level result to the entry
  function automatic ctx_t put(input ctx_t a, input swsp_pkg::byte_res_t r);
    ctx_t b;
    b = a;
    if (a.pl.n == 2'd0) b.pl.r0 = r;
    else                b.pl.r1 = r;
    b.pl.n = a.pl.n + 2'd1;
    return b;
  endfunction

  function automatic ctx_t start_word(input ctx_t a);
    ctx_t b;
    b = a;
    if (a.cnt != swsp_pkg::COUNT_MAX) b.cnt = a.cnt + 1'b1;
    return b;
  endfunction

  // Keep a byte; open a bare word when outside one
  function automatic ctx_t keep(input ctx_t a, input logic [7:0] c);
    ctx_t                b;
    swsp_pkg::byte_res_t r;
    b = a;
    r.ch  = c;
    r.has = 1'b1;
    r.ws  = (a.q == swsp_pkg::MODE_OUT);
    if (r.ws) begin
      b   = start_word(b);
      b.q = swsp_pkg::MODE_BARE;
    end
    return put(b, r);
  endfunction

  function automatic ctx_t plain_byte(input ctx_t a, input logic [7:0] c);
    ctx_t                b;
    swsp_pkg::byte_res_t r;
    b = a;
    r = '0;
    unique case (a.q)
      swsp_pkg::MODE_OUT: begin
        if (c == swsp_pkg::CH_DQUOTE || c == swsp_pkg::CH_SQUOTE) begin
          b   = start_word(b);
          b.q = (c == swsp_pkg::CH_DQUOTE) ? swsp_pkg::MODE_DQ : swsp_pkg::MODE_SQ;
          r.ws = 1'b1;
          b   = put(b, r);
        end else if (c == swsp_pkg::CH_BACKSLASH) begin
          b.p = 1'b1;
        end else if (!is_space(c)) begin
          b = keep(b, c);
        end
      end
      swsp_pkg::MODE_BARE: begin
        if (c == swsp_pkg::CH_DQUOTE)         b.q = swsp_pkg::MODE_DQ;
        else if (c == swsp_pkg::CH_SQUOTE)    b.q = swsp_pkg::MODE_SQ;
        else if (c == swsp_pkg::CH_BACKSLASH) b.p = 1'b1;
        else if (is_space(c))                 b.q = swsp_pkg::MODE_OUT;
        else                                  b = keep(b, c);
      end
      swsp_pkg::MODE_SQ: begin
        if (c == swsp_pkg::CH_SQUOTE) b.q = swsp_pkg::MODE_BARE;
        else                          b = keep(b, c);
      end
      swsp_pkg::MODE_DQ: begin
        if (c == swsp_pkg::CH_DQUOTE)         b.q = swsp_pkg::MODE_BARE;
        else if (c == swsp_pkg::CH_BACKSLASH) b.p = 1'b1;
        else                                  b = keep(b, c);
      end
      default: b = a;
    endcase
    return b;
  endfunction

  always_comb begin
    logic esc;
    x       = '0;
    x.q     = mode;
    x.p     = pend;
    x.cnt   = words;
    esc     = 1'b0;
    if (in_has_char) begin
      if (x.p) begin
        x.p = 1'b0;
        if (x.q == swsp_pkg::MODE_DQ)
          esc = in_char == swsp_pkg::CH_DQUOTE || in_char == swsp_pkg::CH_BACKSLASH;
        else
          esc = in_char == swsp_pkg::CH_DQUOTE || in_char == swsp_pkg::CH_SQUOTE ||
                in_char == swsp_pkg::CH_BACKSLASH || is_space(in_char);
        if (esc) x = keep(x, in_char);
        else     x = keep(x, swsp_pkg::CH_BACKSLASH);
      end
      if (!esc) x = plain_byte(x, in_char);
    end
    if (end_of_string) begin
      // Dangling backslash stays as a literal byte
      if (x.p) begin
        x.p = 1'b0;
        x   = keep(x, swsp_pkg::CH_BACKSLASH);
      end
      x.pl.done  = 1'b1;
      x.pl.count = x.cnt;
    end
  end

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign push_data = x.pl;
  // Drop items that cause no result
  assign push      = accept && (x.pl.n != 2'd0 || x.pl.done);

  always_comb begin
    mode_next  = mode;
    pend_next  = pend;
    words_next = words;
    if (accept) begin
      if (end_of_string) begin
        mode_next  = swsp_pkg::MODE_OUT;
        pend_next  = 1'b0;
        words_next = '0;
      end else begin
        mode_next  = x.q;
        pend_next  = x.p;
        words_next = x.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= swsp_pkg::MODE_OUT;
      pend  <= 1'b0;
      words <= '0;
    end else begin
      mode  <= mode_next;
      pend  <= pend_next;
      words <= words_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swsp_queue.sv =====
// ---------------------------------------------------------------------------
// swsp_queue: work queue
// Short FIFO of work entries between classifier and result sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module swsp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire swsp_pkg::plan_t  push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output swsp_pkg::plan_t       head
);

  swsp_pkg::plan_t                entries [swsp_pkg::QDEPTH];
  logic [swsp_pkg::QAW-1:0]       wr_ptr, rd_ptr;
  logic [swsp_pkg::QAW:0]         count;

  assign full       = count == (swsp_pkg::QAW+1)'(swsp_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swsp_back.sv =====
// ---------------------------------------------------------------------------
// swsp_back: result sequencer
// Each entry goes to the output register one result per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module swsp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire swsp_pkg::plan_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output swsp_pkg::result_t     out_res
);

  logic [1:0]           idx, idx_next;
  logic [1:0]           total;
  logic                 last;
  logic                 load;
  swsp_pkg::byte_res_t  br;
  swsp_pkg::result_t    res;
  logic                 out_valid_next;

  assign total = head.n + {1'b0, head.done};
  assign last  = idx == total - 2'd1;
  assign load  = head_valid && (!out_valid || out_ready);
  assign pop   = load && last;

  always_comb begin
    br  = (idx == 2'd0) ? head.r0 : head.r1;
    res = '0;
    if (idx < head.n) begin
      res.out_char     = br.has ? br.ch : '0;
      res.out_has_char = br.has;
      res.word_start   = br.ws;
    end else begin
      res.string_done  = 1'b1;
      res.word_count   = head.count;
    end
    res.run_last = last;
  end

  always_comb begin
    idx_next       = idx;
    out_valid_next = out_valid;
    if (load) begin
      idx_next       = last ? 2'd0 : idx + 2'd1;
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= res;
  end

endmodule

`default_nettype wire

// ===== rtl/shell_word_splitter.sv =====
// ---------------------------------------------------------------------------
// shell_word_splitter: shell-style command line word splitter
// Split a byte stream into words with quoting and backslash escapes.
// ---------------------------------------------------------------------------
// Feed the string one byte per item; set end_of_string on the last item (a
// bare end item with in_has_char low is fine). Each item yields zero to three
// results: kept bytes, word starts (an opening quote gives a start with no
// byte, so empty quoted words show) and, on an end item, one flush result with
// string_done and the saturating word_count, after which all state returns to
// reset. run_last marks the final result of each item. The classifier takes
// one item per cycle whenever the four-entry work queue has room; the output
// register delivers one result per cycle while out_ready is high, so an item
// holds the output until all its results are taken. The first result of an
// item is written into the queue at its accepting edge and then into the
// output register once that register is free; only then is it shown.
// Items that produce nothing never enter the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module shell_word_splitter (
  input  wire logic   clk,
  input  wire logic   rst,
  swsp_in_if.sink     in_ch,
  swsp_out_if.source  out_ch
);

  logic               q_full;
  logic               push;
  swsp_pkg::plan_t    push_data;
  logic               pop;
  logic               head_valid;
  swsp_pkg::plan_t    head;
  swsp_pkg::result_t  out_res;

  // Classify bytes and track quoting state
  swsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_char       (in_ch.in_char),
    .in_has_char   (in_ch.in_has_char),
    .end_of_string (in_ch.end_of_string),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  // Decouple classifier from output stalls
  swsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Emit results one at a time
  swsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (out_res)
  );

  assign out_ch.out_char     = out_res.out_char;
  assign out_ch.out_has_char = out_res.out_has_char;
  assign out_ch.word_start   = out_res.word_start;
  assign out_ch.string_done  = out_res.string_done;
  assign out_ch.word_count   = out_res.word_count;
  assign out_ch.run_last     = out_res.run_last;

endmodule

`default_nettype wire
